[rtl/core/rfx_pkg.sv]
`default_nettype none

package rfx_pkg;

  // Width of the shared multiply/divide datapath; every product in the sequence fits.
  localparam int MD_W = 56;
  localparam int SR60_W = 22;
  localparam int CNT_W = 40;
  localparam int ROWS_W = 12;
  localparam int PIX_W = 12;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int IMAGE_COLS_DEF = 1809;

  localparam int SEC_PER_MIN = 60;
  // Line edges: 2.5% and 97.5% of a line, compared as m*lpm*2 against sr*3 and sr*117.
  localparam int EDGE_LO_MUL = 3;
  localparam int EDGE_HI_MUL = 117;

  localparam logic [CFG_AW-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LPM         = 3'd1;
  localparam logic [CFG_AW-1:0] REG_START_FREQ  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_START_SEC   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STOP_FREQ   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STOP_SEC    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_PHASING_CNT = 3'd6;
  localparam logic [CFG_AW-1:0] REG_PHASE_INV   = 3'd7;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_PHASING = 3'd1,
    PH_ENDPH   = 3'd2,
    PH_IMAGE   = 3'd3,
    PH_STOP    = 3'd4,
    PH_IDLE    = 3'd5
  } ph_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEN_T,
    ST_LEN_X,
    ST_LEN_Y,
    ST_SR60,
    ST_LINE,
    ST_MOD,
    ST_PH_A,
    ST_PH_B1,
    ST_PH_B2,
    ST_COL_M,
    ST_COL_K,
    ST_COL_DIV,
    ST_ROW_MUL,
    ST_ROW_DIV,
    ST_SQ_MUL,
    ST_SQ_DIV,
    ST_EMIT
  } sq_state_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic            start;
    md_op_t          op;
    logic [MD_W-1:0] a;
    logic [MD_W-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic [MD_W-1:0] q;
    logic [MD_W-1:0] r;
  } md_rsp_t;

endpackage

`default_nettype wire

[rtl/core/rfx_if.sv]
`default_nettype none

interface rfx_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [rfx_pkg::ROWS_W-1:0]   image_rows;

  modport source (output valid, action, image_rows, input ready);
  modport sink (input valid, action, image_rows, output ready);
endinterface

interface rfx_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   phase;
  logic [7:0]                   level;
  logic                         is_pixel;
  logic [rfx_pkg::PIX_W-1:0]    pixel_col;
  logic [rfx_pkg::PIX_W-1:0]    pixel_row;

  modport source (output valid, phase, level, is_pixel, pixel_col, pixel_row, input ready);
  modport sink (input valid, phase, level, is_pixel, pixel_col, pixel_row, output ready);
endinterface

`default_nettype wire

[rtl/core/radiofax_transmit_sequencer.sv]
// A start item is taken and gives no result. A tick is shortest in end phasing
// and longest for an image tick after falling through three empty phases; its
// time is set by the shared serial multiply/divide unit.
// Throughput: one item at a time; the next item is taken once the previous
// result is in the output register. Reset (synchronous, active low) returns the
// sequence to idle and the registers to their defaults; there is no clearing pass.
`default_nettype none

module radiofax_transmit_sequencer #(
  parameter int IMAGE_COLS = rfx_pkg::IMAGE_COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [rfx_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [rfx_pkg::CFG_DW-1:0] cfg_wdata,
  rfx_in_if.sink                          in_ch,
  rfx_out_if.source                       out_ch
);

  localparam int W = rfx_pkg::MD_W;
  localparam int SW = rfx_pkg::SR60_W;
  localparam int NW = rfx_pkg::CNT_W;
  localparam int PW = rfx_pkg::PIX_W;

  logic [15:0] sr_r;
  logic [8:0]  lpm_r;
  logic [11:0] sf_r;
  logic [7:0]  ss_r;
  logic [11:0] pf_r;
  logic [7:0]  ps_r;
  logic [7:0]  plc_r;
  logic        inv_r;

  rfx_pkg::sq_state_t state_r, state_nxt;
  rfx_pkg::ph_t       phase_r;
  rfx_pkg::ph_t       ph_next;
  logic [NW-1:0]      n_r;
  logic [rfx_pkg::ROWS_W-1:0] rows_r;
  logic               pend_r;

  logic [W-1:0]  t_r;
  logic [W-1:0]  x_r;
  logic [SW-1:0] sr60_r;
  logic [SW-1:0] line_r;
  logic [SW-1:0] m_r;
  logic          edge_r;
  logic          lvl_r;
  logic [PW-1:0] col_r;
  logic [PW-1:0] row_r;

  logic          out_valid_r;
  logic [2:0]    out_phase_r;
  logic [7:0]    out_level_r;
  logic          out_pix_r;
  logic [PW-1:0] out_col_r;
  logic [PW-1:0] out_row_r;

  rfx_pkg::md_req_t md_req;
  rfx_pkg::md_rsp_t md_rsp;

  logic          in_fire;
  logic          out_free;
  logic          is_sq;
  logic          len_end;
  logic          op_state;
  logic [NW:0]   n_inc;

  rfx_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign in_ch.ready = (state_r == rfx_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_sq       = (phase_r == rfx_pkg::PH_START) || (phase_r == rfx_pkg::PH_STOP);
  assign n_inc       = {1'b0, n_r} + (NW+1)'(1);
  assign ph_next     = rfx_pkg::ph_t'(phase_r + 3'd1);
  // A phase is used up once its length is not above the count; lengths that
  // floor a division are tested as X < (n+1)*d instead.
  assign len_end     = x_r < md_rsp.q;
  assign op_state    = (state_r != rfx_pkg::ST_IDLE) && (state_r != rfx_pkg::ST_EMIT);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.phase     = out_phase_r;
  assign out_ch.level     = out_level_r;
  assign out_ch.is_pixel  = out_pix_r;
  assign out_ch.pixel_col = out_col_r;
  assign out_ch.pixel_row = out_row_r;

  // Operand selection for the arithmetic unit.
  always_comb begin
    md_req.start = op_state && !pend_r;
    md_req.op    = rfx_pkg::MD_MUL;
    md_req.a     = '0;
    md_req.b     = '0;
    case (state_r)
      rfx_pkg::ST_LEN_T: begin
        md_req.a = W'(sr_r);
        case (phase_r)
          rfx_pkg::PH_START:   md_req.b = W'(ss_r);
          rfx_pkg::PH_PHASING: md_req.b = W'(plc_r);
          rfx_pkg::PH_ENDPH:   md_req.b = W'(1);
          rfx_pkg::PH_IMAGE:   md_req.b = W'(rows_r);
          default:             md_req.b = W'(ps_r);
        endcase
      end
      rfx_pkg::ST_LEN_X: begin
        md_req.a = t_r;
        md_req.b = is_sq ? W'(1) : W'(rfx_pkg::SEC_PER_MIN);
      end
      rfx_pkg::ST_LEN_Y: begin
        md_req.a = W'(n_inc);
        md_req.b = is_sq ? W'(1) : W'(lpm_r);
      end
      rfx_pkg::ST_SR60: begin
        md_req.a = W'(sr_r);
        md_req.b = W'(rfx_pkg::SEC_PER_MIN);
      end
      rfx_pkg::ST_LINE: begin
        md_req.op = rfx_pkg::MD_DIV;
        md_req.a  = W'(sr60_r);
        md_req.b  = W'(lpm_r);
      end
      rfx_pkg::ST_MOD: begin
        md_req.op = rfx_pkg::MD_DIV;
        md_req.a  = W'(n_r);
        md_req.b  = W'(line_r);
      end
      rfx_pkg::ST_PH_A: begin
        md_req.a = W'(m_r);
        md_req.b = W'({lpm_r, 1'b0});
      end
      rfx_pkg::ST_PH_B1: begin
        md_req.a = W'(sr_r);
        md_req.b = W'(rfx_pkg::EDGE_LO_MUL);
      end
      rfx_pkg::ST_PH_B2: begin
        md_req.a = W'(sr_r);
        md_req.b = W'(rfx_pkg::EDGE_HI_MUL);
      end
      rfx_pkg::ST_COL_M: begin
        md_req.a = W'(m_r);
        md_req.b = W'(lpm_r);
      end
      rfx_pkg::ST_COL_K: begin
        md_req.a = t_r;
        md_req.b = W'(IMAGE_COLS);
      end
      rfx_pkg::ST_COL_DIV, rfx_pkg::ST_ROW_DIV: begin
        md_req.op = rfx_pkg::MD_DIV;
        md_req.a  = t_r;
        md_req.b  = W'(sr60_r);
      end
      rfx_pkg::ST_ROW_MUL: begin
        md_req.a = W'(n_r);
        md_req.b = W'(lpm_r);
      end
      rfx_pkg::ST_SQ_MUL: begin
        md_req.a = W'(n_r);
        md_req.b = (phase_r == rfx_pkg::PH_START) ? W'({sf_r, 1'b0}) : W'({pf_r, 1'b0});
      end
      rfx_pkg::ST_SQ_DIV: begin
        md_req.op = rfx_pkg::MD_DIV;
        md_req.a  = t_r;
        md_req.b  = W'(sr_r);
      end
      default: begin
        md_req.a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfx_pkg::ST_IDLE: begin
        if (in_fire && !in_ch.action && phase_r != rfx_pkg::PH_IDLE) begin
          state_nxt = rfx_pkg::ST_LEN_T;
        end
      end
      rfx_pkg::ST_LEN_T: if (md_rsp.done) state_nxt = rfx_pkg::ST_LEN_X;
      rfx_pkg::ST_LEN_X: if (md_rsp.done) state_nxt = rfx_pkg::ST_LEN_Y;
      rfx_pkg::ST_LEN_Y: begin
        if (md_rsp.done) begin
          if (len_end) begin
            state_nxt = (ph_next == rfx_pkg::PH_IDLE) ? rfx_pkg::ST_IDLE : rfx_pkg::ST_LEN_T;
          end else if (is_sq) begin
            state_nxt = rfx_pkg::ST_SQ_MUL;
          end else if (phase_r == rfx_pkg::PH_ENDPH) begin
            state_nxt = rfx_pkg::ST_EMIT;
          end else begin
            state_nxt = rfx_pkg::ST_SR60;
          end
        end
      end
      rfx_pkg::ST_SR60: if (md_rsp.done) state_nxt = rfx_pkg::ST_LINE;
      rfx_pkg::ST_LINE: begin
        if (md_rsp.done) begin
          if (md_rsp.q != '0) begin
            state_nxt = rfx_pkg::ST_MOD;
          end else if (phase_r == rfx_pkg::PH_PHASING) begin
            state_nxt = rfx_pkg::ST_EMIT;
          end else begin
            state_nxt = rfx_pkg::ST_ROW_MUL;
          end
        end
      end
      rfx_pkg::ST_MOD: begin
        if (md_rsp.done) begin
          state_nxt = (phase_r == rfx_pkg::PH_PHASING) ? rfx_pkg::ST_PH_A : rfx_pkg::ST_COL_M;
        end
      end
      rfx_pkg::ST_PH_A:    if (md_rsp.done) state_nxt = rfx_pkg::ST_PH_B1;
      rfx_pkg::ST_PH_B1:   if (md_rsp.done) state_nxt = rfx_pkg::ST_PH_B2;
      rfx_pkg::ST_PH_B2:   if (md_rsp.done) state_nxt = rfx_pkg::ST_EMIT;
      rfx_pkg::ST_COL_M:   if (md_rsp.done) state_nxt = rfx_pkg::ST_COL_K;
      rfx_pkg::ST_COL_K:   if (md_rsp.done) state_nxt = rfx_pkg::ST_COL_DIV;
      rfx_pkg::ST_COL_DIV: if (md_rsp.done) state_nxt = rfx_pkg::ST_ROW_MUL;
      rfx_pkg::ST_ROW_MUL: if (md_rsp.done) state_nxt = rfx_pkg::ST_ROW_DIV;
      rfx_pkg::ST_ROW_DIV: if (md_rsp.done) state_nxt = rfx_pkg::ST_EMIT;
      rfx_pkg::ST_SQ_MUL:  if (md_rsp.done) state_nxt = rfx_pkg::ST_SQ_DIV;
      rfx_pkg::ST_SQ_DIV:  if (md_rsp.done) state_nxt = rfx_pkg::ST_EMIT;
      rfx_pkg::ST_EMIT:    if (out_free) state_nxt = rfx_pkg::ST_IDLE;
      default:             state_nxt = rfx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and sequence control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= 16'd8000;
      lpm_r       <= 9'd120;
      sf_r        <= 12'd300;
      ss_r        <= 8'd5;
      pf_r        <= 12'd450;
      ps_r        <= 8'd5;
      plc_r       <= 8'd20;
      inv_r       <= 1'b0;
      phase_r     <= rfx_pkg::PH_IDLE;
      n_r         <= '0;
      rows_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rfx_pkg::REG_SAMPLE_RATE: sr_r  <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
          rfx_pkg::REG_LPM:         lpm_r <= (cfg_wdata[8:0] == '0) ? 9'd1 : cfg_wdata[8:0];
          rfx_pkg::REG_START_FREQ:  sf_r  <= cfg_wdata[11:0];
          rfx_pkg::REG_START_SEC:   ss_r  <= cfg_wdata[7:0];
          rfx_pkg::REG_STOP_FREQ:   pf_r  <= cfg_wdata[11:0];
          rfx_pkg::REG_STOP_SEC:    ps_r  <= cfg_wdata[7:0];
          rfx_pkg::REG_PHASING_CNT: plc_r <= cfg_wdata[7:0];
          rfx_pkg::REG_PHASE_INV:   inv_r <= cfg_wdata[0];
          default:                  inv_r <= inv_r;
        endcase
      end

      if (md_req.start) begin
        pend_r <= 1'b1;
      end else if (md_rsp.done) begin
        pend_r <= 1'b0;
      end

      if (in_fire && in_ch.action) begin
        phase_r <= rfx_pkg::PH_START;
        n_r     <= '0;
        rows_r  <= in_ch.image_rows;
      end else if (state_r == rfx_pkg::ST_LEN_Y && md_rsp.done && len_end) begin
        phase_r <= ph_next;
        n_r     <= '0;
      end else if (state_r == rfx_pkg::ST_EMIT && out_free) begin
        n_r <= n_inc[NW-1:0];
      end

      if (state_r == rfx_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working values and the output payload.
  always_ff @(posedge clk) begin
    if (md_rsp.done) begin
      case (state_r)
        rfx_pkg::ST_LEN_T: t_r <= md_rsp.q;
        rfx_pkg::ST_LEN_X: x_r <= md_rsp.q;
        rfx_pkg::ST_LEN_Y: lvl_r <= ~inv_r;
        rfx_pkg::ST_SR60:  sr60_r <= md_rsp.q[SW-1:0];
        rfx_pkg::ST_LINE: begin
          line_r <= md_rsp.q[SW-1:0];
          // With no line length a phasing sample counts as mid-line.
          lvl_r  <= inv_r;
          col_r  <= '0;
        end
        rfx_pkg::ST_MOD:     m_r <= md_rsp.r[SW-1:0];
        rfx_pkg::ST_PH_A:    t_r <= md_rsp.q;
        rfx_pkg::ST_PH_B1:   edge_r <= t_r < md_rsp.q;
        rfx_pkg::ST_PH_B2:   lvl_r <= (edge_r || (t_r >= md_rsp.q)) ^ inv_r;
        rfx_pkg::ST_COL_M:   t_r <= md_rsp.q;
        rfx_pkg::ST_COL_K:   t_r <= md_rsp.q;
        rfx_pkg::ST_COL_DIV: col_r <= md_rsp.q[PW-1:0];
        rfx_pkg::ST_ROW_MUL: t_r <= md_rsp.q;
        rfx_pkg::ST_ROW_DIV: row_r <= md_rsp.q[PW-1:0];
        rfx_pkg::ST_SQ_MUL:  t_r <= md_rsp.q;
        rfx_pkg::ST_SQ_DIV:  lvl_r <= md_rsp.q[0];
        default:             t_r <= t_r;
      endcase
    end

    if (state_r == rfx_pkg::ST_EMIT && out_free) begin
      out_phase_r <= phase_r;
      if (phase_r == rfx_pkg::PH_IMAGE) begin
        out_level_r <= 8'd0;
        out_pix_r   <= 1'b1;
        out_col_r   <= col_r;
        out_row_r   <= row_r;
      end else begin
        out_level_r <= lvl_r ? 8'hFF : 8'd0;
        out_pix_r   <= 1'b0;
        out_col_r   <= '0;
        out_row_r   <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> pend_r)
    else $error("arithmetic unit finished with no operation pending");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !pend_r)
    else $error("item accepted while arithmetic is in flight");

  a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_phase_r != 3'(rfx_pkg::PH_IDLE)))
    else $error("result carries the idle phase");

  a_pixel_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pix_r) |-> (out_level_r == 8'd0 &&
                                    out_phase_r == 3'(rfx_pkg::PH_IMAGE)))
    else $error("pixel result outside the image phase or with a level");
`endif

endmodule

`default_nettype wire

[rtl/core/rfx_muldiv.sv]
`default_nettype none

// Shared serial arithmetic: shift-add multiply (one multiplier bit per cycle,
// stops when the remaining multiplier bits are zero) and restoring divide
// (one quotient bit per cycle).
module rfx_muldiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rfx_pkg::md_req_t req,
  output rfx_pkg::md_rsp_t      rsp
);

  localparam int W = rfx_pkg::MD_W;
  localparam int CW = $clog2(W + 1);

  logic             busy_r;
  logic             done_r;
  rfx_pkg::md_op_t  op_r;
  logic [W-1:0]     acc_r;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [CW-1:0]    cnt_r;

  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             qbit;
  logic [W-1:0]     acc_div_nxt;

  assign rem_sh = {acc_r, a_r[W-1]};
  assign diff = rem_sh - {1'b0, b_r};
  assign qbit = ~diff[W];
  assign acc_div_nxt = qbit ? diff[W-1:0] : rem_sh[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if ((op_r == rfx_pkg::MD_MUL && b_r == '0) ||
            (op_r == rfx_pkg::MD_DIV && cnt_r == '0)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
      cnt_r <= CW'(W);
    end else if (busy_r) begin
      if (op_r == rfx_pkg::MD_MUL) begin
        if (b_r != '0) begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
      end else if (cnt_r != '0) begin
        acc_r <= acc_div_nxt;
        a_r   <= {a_r[W-2:0], qbit};
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.q    = (op_r == rfx_pkg::MD_MUL) ? acc_r : a_r;
    rsp.r    = acc_r;
  end

endmodule

`default_nettype wire
